/* src/aimd_pkg.sv */
// Constants, codes and reciprocal factors for the adaptive in-flight limit.
// No dependencies; used by adaptive_inflight_aimd.
package aimd_pkg;

    localparam int TARGET_BITS = 12;
    localparam int COUNT_BITS  = 48;
    localparam int TICK_BITS   = 16;
    localparam int BYTES_BITS  = 32;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam int S_DATA_BITS = 48;   // chunk_bytes, req_target, zero pad
    localparam int M_DATA_BITS = 16;   // target, direction, zero pad

    // Operation codes carried on s_tuser
    localparam logic [1:0] OP_CHUNK = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_FORCE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_TARGET = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_TARGET     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_TARGET     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_TICKS   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STALL_BYTES    = 3'd4;

    localparam logic [TARGET_BITS-1:0] RST_INITIAL_TARGET = TARGET_BITS'(8);
    localparam logic [TARGET_BITS-1:0] RST_MIN_TARGET     = TARGET_BITS'(1);
    localparam logic [TARGET_BITS-1:0] RST_MAX_TARGET     = TARGET_BITS'(64);
    localparam logic [TICK_BITS-1:0]   RST_WINDOW_TICKS   = TICK_BITS'(2000);
    localparam logic [TICK_BITS-1:0]   RST_STALL_BYTES    = TICK_BITS'(2);

    localparam logic [3:0] STALL_MAX  = 4'd15;
    localparam logic [3:0] STALL_CUT  = 4'd3;
    localparam logic [2:0] STABLE_MAX = 3'd7;
    localparam logic [2:0] STABLE_GROW = 3'd2;

    // Reciprocals scaled by 2^32 (rounded up); exact for the operand ranges used
    localparam int RECIP_SHIFT = 32;
    localparam logic [31:0] RECIP_6   = 32'd715827883;
    localparam logic [31:0] RECIP_100 = 32'd42949673;
    localparam logic [31:0] RECIP_5   = 32'd858993460;

endpackage

/* src/adaptive_inflight_aimd.sv */
// Adaptive in-flight request limit: AIMD-style target update on per-window byte counts.
// Depends on aimd_pkg for widths, operation codes, register indexes and reciprocals.
//
// Usage:
//   s_ channel: one word per event. s_tuser holds the operation (chunk done,
//   tick, forced reduction); s_tdata holds chunk_bytes and req_target.
//   m_ channel: one word per accepted input word, carrying the target after
//   the event, the current trend and a flag (m_tuser) set when the event
//   closed a measurement window.
//   cfg_ channel: register writes by index; always ready. The user must write
//   only while no word is in flight; the block does not enforce this. Writing
//   initial_target reloads the current and best-seen targets.
// From input acceptance to m_tvalid a word passes an input register, then the
// update logic feeding the state and the output register.
// Throughput is one word per cycle unless m_tready stalls; the update is combinational.
// Reset loads the register defaults, clears counters and empties both stages.
// When m_tready is low the output word holds, the input register holds its
// word, and s_tready drops once that register is full.
module adaptive_inflight_aimd (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [31:0] chunk_bytes, [43:32] req_target, [47:44] zero
    input  logic [aimd_pkg::S_DATA_BITS-1:0]       s_tdata,
    // [1:0] op
    input  logic [1:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [11:0] target, [12] direction, [15:13] zero
    output logic [aimd_pkg::M_DATA_BITS-1:0]       m_tdata,
    // [0] measured
    output logic                                   m_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [aimd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [aimd_pkg::CFG_BITS-1:0]          cfg_data
);

    localparam int TB = aimd_pkg::TARGET_BITS;
    localparam int CB = aimd_pkg::COUNT_BITS;
    localparam int KB = aimd_pkg::TICK_BITS;
    localparam int PW = CB + 7;

    // configuration
    logic [TB-1:0] min_target_reg, max_target_reg;
    logic [KB-1:0] window_ticks_reg, stall_bytes_reg;

    // block state
    logic [TB-1:0] cur_target_reg, cur_target_next;
    logic [TB-1:0] best_seen_reg, best_seen_next;
    logic [CB-1:0] window_bytes_reg, window_bytes_next;
    logic [CB-1:0] prev_bytes_reg, prev_bytes_next;
    logic [KB-1:0] tick_count_reg, tick_count_next;
    logic [3:0]    stall_runs_reg, stall_runs_next;
    logic [2:0]    stable_runs_reg, stable_runs_next;
    logic          trend_down_reg, trend_down_next;

    // input and output stages
    logic                                 in_valid_reg;
    logic [1:0]                           in_op_reg;
    logic [aimd_pkg::BYTES_BITS-1:0]      in_bytes_reg;
    logic [TB-1:0]                        in_nt_reg;
    logic                                 out_valid_reg;
    logic [TB-1:0]                        out_target_reg;
    logic                                 out_measured_reg;
    logic                                 out_dir_reg;

    logic advance, stage_fire, s_fire, cfg_fire, measured;

    // datapath
    logic [CB:0]     wb_sum;
    logic [KB-1:0]   tick_inc;
    logic [3:0]      stall_inc;
    logic [2:0]      stable_inc;
    logic [CB-1:0]   stall_ext;
    logic [PW-1:0]   b100, p60, p103, p90;
    logic            is_stall, is_severe, is_growth, is_nudge;
    logic [TB+2:0]   cur_x5;
    logic [TB+6:0]   cur_x85;
    logic [TB+34:0]  prod6;
    logic [TB+38:0]  prod100;
    logic [TB+29:0]  prod5;
    logic [TB-1:0]   q6, q100, q20;
    logic [TB-1:0]   cut6, cut85;
    logic [TB-1:0]   grow_step, grow_val, nudge_step, nudge_dif, nudge_val;
    logic [TB:0]     grow_sum, stable_sum, first_sum;
    logic [TB-1:0]   best_up, stable_step, stable_val, first_step, first_val;
    logic [TB+1:0]   best34;
    logic [TB-1:0]   force_val;

    assign advance    = !out_valid_reg || m_tready;
    assign stage_fire = in_valid_reg && advance;
    assign s_tready   = !in_valid_reg || advance;
    assign s_fire     = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;

    // ---------------- window evaluation candidates ----------------
    assign stall_ext = CB'(stall_bytes_reg);
    assign b100 = (PW'(window_bytes_reg) << 6) + (PW'(window_bytes_reg) << 5)
                + (PW'(window_bytes_reg) << 2);
    assign p60  = (PW'(prev_bytes_reg) << 6) - (PW'(prev_bytes_reg) << 2);
    assign p90  = (PW'(prev_bytes_reg) << 6) + (PW'(prev_bytes_reg) << 4)
                + (PW'(prev_bytes_reg) << 3) + (PW'(prev_bytes_reg) << 1);
    assign p103 = (PW'(prev_bytes_reg) << 6) + (PW'(prev_bytes_reg) << 5)
                + (PW'(prev_bytes_reg) << 2) + (PW'(prev_bytes_reg) << 1)
                + PW'(prev_bytes_reg);

    assign is_stall  = (window_bytes_reg < stall_ext) && (prev_bytes_reg > stall_ext);
    assign is_severe = b100 < p60;
    assign is_growth = p103 < b100;
    assign is_nudge  = b100 < p90;

    // gentle cuts: target*5/6 and target*85/100 through reciprocals
    assign cur_x5  = (TB+3)'(cur_target_reg) + ((TB+3)'(cur_target_reg) << 2);
    assign cur_x85 = ((TB+7)'(cur_target_reg) << 6) + ((TB+7)'(cur_target_reg) << 4)
                   + ((TB+7)'(cur_target_reg) << 2) + (TB+7)'(cur_target_reg);
    assign prod6   = (TB+35)'(cur_x5) * (TB+35)'(aimd_pkg::RECIP_6);
    assign prod100 = (TB+39)'(cur_x85) * (TB+39)'(aimd_pkg::RECIP_100);
    assign prod5   = (TB+30)'(cur_target_reg[TB-1:2]) * (TB+30)'(aimd_pkg::RECIP_5);
    assign q6   = prod6[aimd_pkg::RECIP_SHIFT +: TB];
    assign q100 = prod100[aimd_pkg::RECIP_SHIFT +: TB];
    assign q20  = TB'(prod5[aimd_pkg::RECIP_SHIFT +: TB-2]);

    assign cut6  = (q6 < min_target_reg) ? min_target_reg : q6;
    assign cut85 = (q100 < min_target_reg) ? min_target_reg : q100;

    // additive growth of a quarter
    assign grow_step = (cur_target_reg[TB-1:2] == '0) ? TB'(1) : TB'(cur_target_reg[TB-1:2]);
    assign grow_sum  = (TB+1)'(cur_target_reg) + (TB+1)'(grow_step);
    assign grow_val  = (grow_sum > (TB+1)'(max_target_reg)) ? max_target_reg : grow_sum[TB-1:0];

    // 5% nudge down
    assign nudge_step = (q20 == '0) ? TB'(1) : q20;
    assign nudge_dif  = (nudge_step >= cur_target_reg) ? '0 : cur_target_reg - nudge_step;
    assign nudge_val  = (nudge_dif < min_target_reg) ? min_target_reg : nudge_dif;

    // stable probing
    assign best_up     = (cur_target_reg > best_seen_reg) ? cur_target_reg : best_seen_reg;
    assign best34      = ((TB+2)'(best_up) + ((TB+2)'(best_up) << 1)) >> 2;
    assign stable_step = ((TB+2)'(cur_target_reg) < best34 && cur_target_reg[TB-1:3] != '0)
                       ? TB'(cur_target_reg[TB-1:3]) : TB'(1);
    assign stable_sum  = (TB+1)'(cur_target_reg) + (TB+1)'(stable_step);
    assign stable_val  = (stable_sum > (TB+1)'(max_target_reg))
                       ? max_target_reg : stable_sum[TB-1:0];

    // first-window ramp
    assign first_step = (cur_target_reg[TB-1:1] < (TB-1)'(2)) ? TB'(2)
                      : TB'(cur_target_reg[TB-1:1]);
    assign first_sum  = (TB+1)'(cur_target_reg) + (TB+1)'(first_step);
    assign first_val  = (first_sum > (TB+1)'(max_target_reg))
                      ? max_target_reg : first_sum[TB-1:0];

    assign force_val = (in_nt_reg < min_target_reg) ? min_target_reg : in_nt_reg;

    assign wb_sum     = (CB+1)'(window_bytes_reg) + (CB+1)'(in_bytes_reg);
    assign tick_inc   = (tick_count_reg != '1) ? tick_count_reg + KB'(1) : tick_count_reg;
    assign stall_inc  = (stall_runs_reg < aimd_pkg::STALL_MAX)
                      ? stall_runs_reg + 4'd1 : stall_runs_reg;
    assign stable_inc = (stable_runs_reg < aimd_pkg::STABLE_MAX)
                      ? stable_runs_reg + 3'd1 : stable_runs_reg;

    // ---------------- next state ----------------
    always_comb begin
        cur_target_next   = cur_target_reg;
        best_seen_next    = best_seen_reg;
        window_bytes_next = window_bytes_reg;
        prev_bytes_next   = prev_bytes_reg;
        tick_count_next   = tick_count_reg;
        stall_runs_next   = stall_runs_reg;
        stable_runs_next  = stable_runs_reg;
        trend_down_next   = trend_down_reg;
        measured          = 1'b0;
        if (stage_fire) begin
            case (in_op_reg)
                aimd_pkg::OP_CHUNK: begin
                    window_bytes_next = wb_sum[CB] ? '1 : wb_sum[CB-1:0];
                end
                aimd_pkg::OP_TICK: begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= window_ticks_reg) begin
                        measured = 1'b1;
                        if (is_stall) begin
                            stall_runs_next = stall_inc;
                            if (stall_inc >= aimd_pkg::STALL_CUT) begin
                                cur_target_next  = cut6;
                                trend_down_next  = 1'b1;
                                stable_runs_next = '0;
                            end
                        end else if (prev_bytes_reg != '0) begin
                            if (is_severe) begin
                                stall_runs_next = stall_inc;
                                if (stall_inc >= aimd_pkg::STALL_CUT) begin
                                    cur_target_next  = cut85;
                                    trend_down_next  = 1'b1;
                                    stable_runs_next = '0;
                                end
                            end else if (is_growth) begin
                                stable_runs_next = '0;
                                stall_runs_next  = '0;
                                trend_down_next  = 1'b0;
                                best_seen_next   = best_up;
                                if (cur_target_reg < max_target_reg) begin
                                    cur_target_next = grow_val;
                                end
                            end else if (is_nudge) begin
                                stable_runs_next = '0;
                                trend_down_next  = 1'b1;
                                if (cur_target_reg > min_target_reg) begin
                                    cur_target_next = nudge_val;
                                end
                            end else begin
                                stall_runs_next = '0;
                                best_seen_next  = best_up;
                                if (stable_inc >= aimd_pkg::STABLE_GROW &&
                                    cur_target_reg < max_target_reg) begin
                                    cur_target_next  = stable_val;
                                    stable_runs_next = '0;
                                    trend_down_next  = 1'b0;
                                end else begin
                                    stable_runs_next = stable_inc;
                                end
                            end
                        end else begin
                            stall_runs_next = '0;
                            if (cur_target_reg < max_target_reg) begin
                                cur_target_next = first_val;
                            end
                        end
                        prev_bytes_next   = window_bytes_reg;
                        window_bytes_next = '0;
                        tick_count_next   = '0;
                    end
                end
                aimd_pkg::OP_FORCE: begin
                    cur_target_next  = force_val;
                    trend_down_next  = 1'b1;
                    stable_runs_next = '0;
                    stall_runs_next  = stall_inc;
                    prev_bytes_next  = '0;
                end
                default: begin
                    // unused code: state holds
                end
            endcase
        end
    end

    // ---------------- state and configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_target_reg     <= aimd_pkg::RST_MIN_TARGET;
            max_target_reg     <= aimd_pkg::RST_MAX_TARGET;
            window_ticks_reg   <= aimd_pkg::RST_WINDOW_TICKS;
            stall_bytes_reg    <= aimd_pkg::RST_STALL_BYTES;
            cur_target_reg     <= aimd_pkg::RST_INITIAL_TARGET;
            best_seen_reg      <= aimd_pkg::RST_INITIAL_TARGET;
            window_bytes_reg   <= '0;
            prev_bytes_reg     <= '0;
            tick_count_reg     <= '0;
            stall_runs_reg     <= '0;
            stable_runs_reg    <= '0;
            trend_down_reg     <= 1'b0;
        end else begin
            cur_target_reg   <= cur_target_next;
            best_seen_reg    <= best_seen_next;
            window_bytes_reg <= window_bytes_next;
            prev_bytes_reg   <= prev_bytes_next;
            tick_count_reg   <= tick_count_next;
            stall_runs_reg   <= stall_runs_next;
            stable_runs_reg  <= stable_runs_next;
            trend_down_reg   <= trend_down_next;
            if (cfg_fire) begin
                unique case (cfg_index)
                    aimd_pkg::CFG_INITIAL_TARGET: begin
                        // the initial target only matters as a reload of both targets
                        cur_target_reg     <= cfg_data[TB-1:0];
                        best_seen_reg      <= cfg_data[TB-1:0];
                    end
                    aimd_pkg::CFG_MIN_TARGET:   min_target_reg   <= cfg_data[TB-1:0];
                    aimd_pkg::CFG_MAX_TARGET:   max_target_reg   <= cfg_data[TB-1:0];
                    aimd_pkg::CFG_WINDOW_TICKS: window_ticks_reg <= cfg_data[KB-1:0];
                    aimd_pkg::CFG_STALL_BYTES:  stall_bytes_reg  <= cfg_data[KB-1:0];
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
        end
    end

    // ---------------- input and output stages ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg    <= s_tuser;
            in_bytes_reg <= s_tdata[aimd_pkg::BYTES_BITS-1:0];
            in_nt_reg    <= s_tdata[aimd_pkg::BYTES_BITS +: TB];
        end
        if (stage_fire) begin
            out_target_reg   <= cur_target_next;
            out_measured_reg <= measured;
            out_dir_reg      <= trend_down_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_measured_reg;
    assign m_tdata  = {(aimd_pkg::M_DATA_BITS - TB - 1)'(0), out_dir_reg, out_target_reg};

    // ---------------- assertions ----------------
    a_measured_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_fire && in_op_reg != aimd_pkg::OP_TICK |=> !out_measured_reg)
        else $error("window flagged on a non-tick word");

    a_window_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_fire && measured |=> tick_count_reg == '0 && window_bytes_reg == '0)
        else $error("window counters not cleared after evaluation");

    a_ready_when_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    a_out_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_fire && !cfg_fire |=> out_target_reg == cur_target_reg &&
                                   out_dir_reg == trend_down_reg)
        else $error("output word disagrees with updated state");

endmodule
